FILE: sv/swm_pkg.sv
// Shared constants and types for the sliding window median filter.
package swm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WINDOW_SIZE_DEF = 7;

	typedef struct packed {
		logic                valid;
		logic                ge;
		logic [SAMPLE_W-1:0] value;
	} cell_stat_t;

endpackage

FILE: sv/sliding_window_median.sv
// Top level of the running median filter built from a chain of sorted cells.
//
//   channel   signals                                 direction
//   sample    sample_valid, sample_ready, sample      in
//   median    median_valid, median_ready, median_value out
//
// Each accepted sample updates the sorted chain in the cycle of its transfer,
// and its median is offered from the next cycle on, so one sample per cycle unless median_ready stalls it.
// The chain update is a single pass through the cells, with the removal flag
// rippling from the largest cell to the smallest.
// Reset empties the window; a new sample is taken whenever the result register
// is empty or its result is transferred at the same edge.
module sliding_window_median
	import swm_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                median_valid,
	input  logic                median_ready,
	output logic [SAMPLE_W-1:0] median_value
);

	localparam int AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
	localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

	logic                out_valid_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                take;
	logic [SAMPLE_W-1:0] smp;
	logic [IDX_W-1:0]    idx;
	cell_stat_t          stat [WINDOW_SIZE];
	logic [AGE_W-1:0]    age [WINDOW_SIZE];
	logic                rm [WINDOW_SIZE+1];
	cell_stat_t          top_stat;
	cell_stat_t          end_stat;

	assign sample_ready = !out_valid_q || median_ready;
	assign take = sample_valid && sample_ready;
	assign smp = (sample == '0) ? SAMPLE_W'(1) : sample;
	assign median_valid = out_valid_q;
	assign idx = IDX_W'(cnt_q >> 1);
	assign median_value = stat[idx].value;

	// The boundary above the chain ranks above any sample; the one below is empty.
	assign top_stat.valid = 1'b1;
	assign top_stat.ge = 1'b1;
	assign top_stat.value = '0;
	assign end_stat.valid = 1'b0;
	assign end_stat.ge = 1'b0;
	assign end_stat.value = '0;
	assign rm[0] = 1'b0;

	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
		swm_cell #(
			.WINDOW_SIZE(WINDOW_SIZE)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (take),
			.smp      (smp),
			.prev_stat((i == 0) ? top_stat : stat[(i == 0) ? 0 : i - 1]),
			.prev_age ((i == 0) ? '0 : age[(i == 0) ? 0 : i - 1]),
			.next_stat((i == WINDOW_SIZE - 1) ? end_stat
				: stat[(i == WINDOW_SIZE - 1) ? i : i + 1]),
			.next_age ((i == WINDOW_SIZE - 1) ? '0
				: age[(i == WINDOW_SIZE - 1) ? i : i + 1]),
			.rm_in    (rm[i]),
			.stat     (stat[i]),
			.age      (age[i]),
			.rm_out   (rm[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				if (cnt_q != CNT_W'(WINDOW_SIZE)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (median_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/swm_cell.sv
// One cell of the sorted window chain, holding a sample and its age.
module swm_cell
	import swm_pkg::*;
#(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
	localparam int AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [SAMPLE_W-1:0] smp,
	input  cell_stat_t          prev_stat,
	input  logic [AGE_W-1:0]    prev_age,
	input  cell_stat_t          next_stat,
	input  logic [AGE_W-1:0]    next_age,
	input  logic                rm_in,
	output cell_stat_t          stat,
	output logic [AGE_W-1:0]    age,
	output logic                rm_out
);

	logic                valid_q;
	logic [SAMPLE_W-1:0] value_q;
	logic [AGE_W-1:0]    age_q;
	logic                del;
	cell_stat_t          self_stat;
	cell_stat_t          cur_sel;
	cell_stat_t          prev_sel;
	logic [AGE_W-1:0]    cur_age;
	logic [AGE_W-1:0]    prev_sel_age;
	logic                valid_d;
	logic [SAMPLE_W-1:0] value_d;
	logic [AGE_W-1:0]    age_d;

	// The oldest sample leaves the window once the window is full.
	assign del = valid_q && (age_q == AGE_W'(WINDOW_SIZE - 1));
	assign self_stat.valid = valid_q;
	assign self_stat.ge = valid_q && (value_q >= smp);
	assign self_stat.value = value_q;
	assign stat = self_stat;
	assign age = age_q;
	assign rm_out = rm_in | del;

	always_comb begin
		cur_sel = rm_out ? next_stat : self_stat;
		cur_age = rm_out ? next_age : age_q;
		prev_sel = rm_in ? self_stat : prev_stat;
		prev_sel_age = rm_in ? age_q : prev_age;
		if (cur_sel.ge) begin
			valid_d = cur_sel.valid;
			value_d = cur_sel.value;
			age_d = cur_age + AGE_W'(1);
		end else if (prev_sel.ge) begin
			valid_d = 1'b1;
			value_d = smp;
			age_d = '0;
		end else begin
			valid_d = prev_sel.valid;
			value_d = prev_sel.value;
			age_d = prev_sel_age + AGE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= value_d;
			age_q <= age_d;
		end
	end

endmodule
